>>> rtl/circle_track_association_top_defines.svh
// Assertion macros shared by the circle track association RTL.
`ifndef CIRCLE_TRACK_ASSOCIATION_TOP_DEFINES_SVH
`define CIRCLE_TRACK_ASSOCIATION_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define CTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/cta_pkg.sv
// Types, constants and codes shared by the circle track association block.
`default_nettype none

package cta_pkg;

	localparam int MAX_TRACKS = 16;
	localparam int COORD_BITS = 12;
	localparam int ID_BITS    = 16;
	localparam int RAD_BITS   = COORD_BITS - 1;
	localparam int MISS_BITS  = 8;
	localparam int HALF_BITS  = RAD_BITS - 1;
	localparam int LIM_BITS   = 2 * HALF_BITS;
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int SUM_BITS   = SQ_BITS + 1;
	localparam int ADDR_BITS  = 3;
	localparam int DATA_BITS  = 32;

	localparam logic [MISS_BITS-1:0] MISS_MAX         = '1;
	localparam logic [MISS_BITS-1:0] MAX_MISSED_RESET = MISS_BITS'(5);

	// Register index, taken from the word address bits of paddr.
	localparam logic [ADDR_BITS-3:0] REG_MAX_MISSED = '0;

	localparam logic OP_END_FRAME = 1'b1;

	typedef enum logic [1:0] {
		KIND_DETECT = 2'd0,
		KIND_TRACK  = 2'd1,
		KIND_EMPTY  = 2'd2
	} kind_t;

	typedef struct packed {
		logic                  op;
		logic [COORD_BITS-1:0] center_x;
		logic [COORD_BITS-1:0] center_y;
		logic [RAD_BITS-1:0]   radius;
	} item_t;

	typedef struct packed {
		kind_t                 kind;
		logic [ID_BITS-1:0]    track_id;
		logic [COORD_BITS-1:0] track_x;
		logic [COORD_BITS-1:0] track_y;
		logic [RAD_BITS-1:0]   track_radius;
		logic                  is_new;
		logic                  table_full;
		logic                  last;
	} result_t;

	typedef struct packed {
		logic [ID_BITS-1:0]    ident;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [RAD_BITS-1:0]   rad;
		logic [MISS_BITS-1:0]  missed;
	} slot_word_t;

	typedef enum logic [1:0] {
		MODE_DETECT = 2'd0,
		MODE_AGE    = 2'd1,
		MODE_SELECT = 2'd2
	} scan_mode_t;

	typedef struct packed {
		logic       load;
		logic       issue;
		scan_mode_t mode;
		logic       det_commit;
		logic       hit_clear;
		logic       sel_clear;
		logic       emit_list;
		logic       emit_empty;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic surv_zero;
		logic last_one;
	} status_t;

endpackage

`default_nettype wire

>>> rtl/cta_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/cta_ctrl.sv
// Controller state machine that sequences slot scans, commits and result beats.
`default_nettype none

module cta_ctrl #(
	parameter int MAX_TRACKS = cta_pkg::MAX_TRACKS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          op,
	input  wire cta_pkg::status_t              status,
	output cta_pkg::cmd_t                      cmd,
	output logic [$clog2(MAX_TRACKS)-1:0]      issue_slot,
	output logic                               busy
);

	localparam int SLOT_BITS = $clog2(MAX_TRACKS);
	localparam int PTR_BITS  = SLOT_BITS + 1;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_DSCAN   = 7'b0000010,
		ST_DCOMMIT = 7'b0000100,
		ST_ASCAN   = 7'b0001000,
		ST_AEND    = 7'b0010000,
		ST_LSCAN   = 7'b0100000,
		ST_LEMIT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [PTR_BITS-1:0] ptr_q;
	logic ptr_done;
	logic scan_over;

	assign ptr_done   = (ptr_q == PTR_BITS'(MAX_TRACKS));
	assign scan_over  = ptr_done && !status.pipe_busy;
	assign issue_slot = ptr_q[SLOT_BITS-1:0];
	assign busy       = (state_q != ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.mode       = cta_pkg::MODE_DETECT;
		cmd.load       = (state_q == ST_IDLE) && start;
		cmd.det_commit = (state_q == ST_DCOMMIT);
		cmd.hit_clear  = (state_q == ST_AEND);
		cmd.emit_empty = (state_q == ST_AEND) && status.surv_zero;
		cmd.emit_list  = (state_q == ST_LEMIT);
		cmd.sel_clear  = ((state_q == ST_AEND) && !status.surv_zero) ||
		                 ((state_q == ST_LEMIT) && !status.last_one);
		case (state_q)
			ST_DSCAN: begin
				cmd.issue = !ptr_done;
				cmd.mode  = cta_pkg::MODE_DETECT;
			end
			ST_ASCAN: begin
				cmd.issue = !ptr_done;
				cmd.mode  = cta_pkg::MODE_AGE;
			end
			ST_LSCAN: begin
				cmd.issue = !ptr_done;
				cmd.mode  = cta_pkg::MODE_SELECT;
			end
			default: begin
				cmd.issue = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (op == cta_pkg::OP_END_FRAME) ? ST_ASCAN : ST_DSCAN;
				end
			end
			ST_DSCAN: begin
				if (scan_over) begin
					state_d = ST_DCOMMIT;
				end
			end
			ST_DCOMMIT: begin
				state_d = ST_IDLE;
			end
			ST_ASCAN: begin
				if (scan_over) begin
					state_d = ST_AEND;
				end
			end
			ST_AEND: begin
				state_d = status.surv_zero ? ST_IDLE : ST_LSCAN;
			end
			ST_LSCAN: begin
				if (scan_over) begin
					state_d = ST_LEMIT;
				end
			end
			ST_LEMIT: begin
				state_d = status.last_one ? ST_IDLE : ST_LSCAN;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load || cmd.sel_clear) begin
				ptr_q <= '0;
			end else if (cmd.issue) begin
				ptr_q <= ptr_q + PTR_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/cta_dp.sv
// Datapath: slot table, distance pipeline, age comparison and result register.
`default_nettype none

module cta_dp #(
	parameter int MAX_TRACKS = cta_pkg::MAX_TRACKS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire cta_pkg::cmd_t                        cmd,
	input  wire logic [$clog2(MAX_TRACKS)-1:0]        issue_slot,
	input  wire cta_pkg::item_t                       item,
	input  wire logic [cta_pkg::MISS_BITS-1:0]        max_missed,
	output cta_pkg::status_t                          status,
	output logic                                      result_valid,
	output cta_pkg::result_t                          result
);

	localparam int SLOT_BITS = $clog2(MAX_TRACKS);
	localparam int CNT_BITS  = $clog2(MAX_TRACKS + 1);
	localparam int WORD_BITS = $bits(cta_pkg::slot_word_t);

	// Latched detection and its squared half radius.
	logic [cta_pkg::COORD_BITS-1:0] x_q, y_q;
	logic [cta_pkg::RAD_BITS-1:0]   r_q;
	logic [cta_pkg::LIM_BITS-1:0]   lim_q;
	logic [cta_pkg::HALF_BITS-1:0]  half;

	logic [cta_pkg::ID_BITS-1:0] next_id_q;
	logic [MAX_TRACKS-1:0]       valid_q, hit_q, emitted_q;
	logic [CNT_BITS-1:0]         surv_q;

	logic                        best_found_q, free_found_q, sel_found_q;
	logic [SLOT_BITS-1:0]        best_slot_q, free_slot_q, sel_slot_q;
	logic [cta_pkg::ID_BITS-1:0] best_age_q, sel_age_q;
	cta_pkg::slot_word_t         best_word_q, sel_word_q;

	// Scan pipeline: RAM read, absolute differences, squares.
	logic                           tag_s1, tag_s2, tag_s3;
	logic [SLOT_BITS-1:0]           slot_s1, slot_s2, slot_s3;
	cta_pkg::slot_word_t            word_s2, word_s3;
	logic [cta_pkg::COORD_BITS-1:0] dx_s2, dy_s2;
	logic [cta_pkg::SQ_BITS-1:0]    dx2_s3, dy2_s3;

	logic [WORD_BITS-1:0] ram_rdata, ram_wdata;
	logic                 ram_we;
	logic [SLOT_BITS-1:0] ram_waddr;
	cta_pkg::slot_word_t  rd_word, wr_word;

	logic [cta_pkg::SUM_BITS-1:0]  sum3;
	logic                          match3, vld3, drop3;
	logic [cta_pkg::ID_BITS-1:0]   age3;
	logic [cta_pkg::MISS_BITS-1:0] miss_inc, miss_new;
	logic                          det_step, age_step, sel_step;

	logic                    res_valid_q;
	cta_pkg::result_t        res_q;

	cta_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAX_TRACKS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.issue),
		.raddr (issue_slot),
		.rdata (ram_rdata)
	);

	assign rd_word = cta_pkg::slot_word_t'(ram_rdata);
	assign half    = item.radius[cta_pkg::RAD_BITS-1:1];

	// Decision stage works on the squares registered in stage three.
	assign sum3     = cta_pkg::SUM_BITS'(dx2_s3) + cta_pkg::SUM_BITS'(dy2_s3);
	assign match3   = (sum3 < cta_pkg::SUM_BITS'(lim_q));
	assign age3     = next_id_q - word_s3.ident;
	assign vld3     = valid_q[slot_s3];
	assign miss_inc = (word_s3.missed == cta_pkg::MISS_MAX) ? cta_pkg::MISS_MAX :
	                  word_s3.missed + cta_pkg::MISS_BITS'(1);
	assign miss_new = hit_q[slot_s3] ? '0 : miss_inc;
	assign drop3    = !hit_q[slot_s3] && (miss_new > max_missed);
	assign det_step = tag_s3 && (cmd.mode == cta_pkg::MODE_DETECT);
	assign age_step = tag_s3 && (cmd.mode == cta_pkg::MODE_AGE);
	assign sel_step = tag_s3 && (cmd.mode == cta_pkg::MODE_SELECT);

	always_comb begin
		ram_we         = 1'b0;
		ram_waddr      = slot_s3;
		wr_word        = word_s3;
		wr_word.missed = miss_new;
		if (age_step && vld3 && !drop3) begin
			ram_we = 1'b1;
		end
		if (cmd.det_commit) begin
			if (best_found_q) begin
				ram_we         = 1'b1;
				ram_waddr      = best_slot_q;
				wr_word.ident  = best_word_q.ident;
				wr_word.missed = best_word_q.missed;
			end else begin
				ram_we         = free_found_q;
				ram_waddr      = free_slot_q;
				wr_word.ident  = next_id_q;
				wr_word.missed = '0;
			end
			wr_word.x   = x_q;
			wr_word.y   = y_q;
			wr_word.rad = r_q;
		end
	end

	assign ram_wdata = WORD_BITS'(wr_word);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q    <= '0;
			valid_q      <= '0;
			hit_q        <= '0;
			emitted_q    <= '0;
			surv_q       <= '0;
			best_found_q <= 1'b0;
			free_found_q <= 1'b0;
			sel_found_q  <= 1'b0;
			tag_s1       <= 1'b0;
			tag_s2       <= 1'b0;
			tag_s3       <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			tag_s1      <= cmd.issue;
			tag_s2      <= tag_s1;
			tag_s3      <= tag_s2;
			res_valid_q <= cmd.det_commit || cmd.emit_list || cmd.emit_empty;

			if (cmd.load) begin
				surv_q       <= '0;
				emitted_q    <= '0;
				best_found_q <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (cmd.sel_clear) begin
				sel_found_q <= 1'b0;
			end

			if (det_step) begin
				if (vld3) begin
					if (match3 && (!best_found_q || age3 > best_age_q)) begin
						best_found_q <= 1'b1;
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
				end
			end

			if (age_step && vld3) begin
				if (drop3) begin
					valid_q[slot_s3] <= 1'b0;
				end else begin
					surv_q <= surv_q + CNT_BITS'(1);
				end
			end

			if (sel_step && vld3 && !emitted_q[slot_s3]) begin
				if (!sel_found_q || age3 > sel_age_q) begin
					sel_found_q <= 1'b1;
				end
			end

			if (cmd.det_commit) begin
				if (best_found_q) begin
					hit_q[best_slot_q] <= 1'b1;
				end else if (free_found_q) begin
					valid_q[free_slot_q] <= 1'b1;
					hit_q[free_slot_q]   <= 1'b1;
					next_id_q            <= next_id_q + cta_pkg::ID_BITS'(1);
				end
			end

			if (cmd.hit_clear) begin
				hit_q <= '0;
			end

			if (cmd.emit_list) begin
				emitted_q[sel_slot_q] <= 1'b1;
				surv_q                <= surv_q - CNT_BITS'(1);
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		slot_s1 <= issue_slot;
		slot_s2 <= slot_s1;
		slot_s3 <= slot_s2;
		word_s2 <= rd_word;
		dx_s2   <= (rd_word.x > x_q) ? rd_word.x - x_q : x_q - rd_word.x;
		dy_s2   <= (rd_word.y > y_q) ? rd_word.y - y_q : y_q - rd_word.y;
		word_s3 <= word_s2;
		dx2_s3  <= cta_pkg::SQ_BITS'(dx_s2 * dx_s2);
		dy2_s3  <= cta_pkg::SQ_BITS'(dy_s2 * dy_s2);

		if (cmd.load) begin
			x_q   <= item.center_x;
			y_q   <= item.center_y;
			r_q   <= item.radius;
			lim_q <= cta_pkg::LIM_BITS'(half * half);
		end

		if (det_step && vld3 && match3 && (!best_found_q || age3 > best_age_q)) begin
			best_slot_q <= slot_s3;
			best_age_q  <= age3;
			best_word_q <= word_s3;
		end
		if (det_step && !vld3 && !free_found_q) begin
			free_slot_q <= slot_s3;
		end
		if (sel_step && vld3 && !emitted_q[slot_s3] && (!sel_found_q || age3 > sel_age_q)) begin
			sel_slot_q <= slot_s3;
			sel_age_q  <= age3;
			sel_word_q <= word_s3;
		end

		if (cmd.det_commit) begin
			res_q.kind         <= cta_pkg::KIND_DETECT;
			res_q.track_id     <= best_found_q ? best_word_q.ident :
			                      free_found_q ? next_id_q : '0;
			res_q.track_x      <= x_q;
			res_q.track_y      <= y_q;
			res_q.track_radius <= r_q;
			res_q.is_new       <= !best_found_q && free_found_q;
			res_q.table_full   <= !best_found_q && !free_found_q;
			res_q.last         <= 1'b1;
		end else if (cmd.emit_list) begin
			res_q.kind         <= cta_pkg::KIND_TRACK;
			res_q.track_id     <= sel_word_q.ident;
			res_q.track_x      <= sel_word_q.x;
			res_q.track_y      <= sel_word_q.y;
			res_q.track_radius <= sel_word_q.rad;
			res_q.is_new       <= 1'b0;
			res_q.table_full   <= 1'b0;
			res_q.last         <= (surv_q == CNT_BITS'(1));
		end else if (cmd.emit_empty) begin
			res_q.kind         <= cta_pkg::KIND_EMPTY;
			res_q.track_id     <= '0;
			res_q.track_x      <= '0;
			res_q.track_y      <= '0;
			res_q.track_radius <= '0;
			res_q.is_new       <= 1'b0;
			res_q.table_full   <= 1'b0;
			res_q.last         <= 1'b1;
		end
	end

	assign status.pipe_busy = tag_s1 || tag_s2 || tag_s3;
	assign status.surv_zero = (surv_q == '0);
	assign status.last_one  = (surv_q == CNT_BITS'(1));
	assign result_valid     = res_valid_q;
	assign result           = res_q;

endmodule

`default_nettype wire

>>> rtl/circle_track_association_top.sv
// Top level of the circle track association block. For a detection beat the
// slot table is a single-port-read RAM scanned one slot per cycle through a
// three-stage distance pipeline, then the match or new track is committed.
// An end-of-frame beat runs the aging pass and then one oldest-first selection
// pass per surviving track, each of them one full table scan.
// Each result appears for exactly one cycle with result_valid high and is not
// held, because the receiver cannot stall; the last result of an item shows
// in the first cycle with busy low, when a new item may already be started.
`default_nettype none
`include "circle_track_association_top_defines.svh"

module circle_track_association_top #(
	parameter int MAX_TRACKS = cta_pkg::MAX_TRACKS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire cta_pkg::item_t                item,
	output logic                               result_valid,
	output cta_pkg::result_t                   result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cta_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [cta_pkg::DATA_BITS-1:0] pwdata,
	output logic      [cta_pkg::DATA_BITS-1:0] prdata,
	output logic                               pready
);

	cta_pkg::cmd_t                 cmd;
	cta_pkg::status_t              status;
	logic [$clog2(MAX_TRACKS)-1:0] issue_slot;
	logic [cta_pkg::MISS_BITS-1:0] max_missed_q;
	logic                          reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[cta_pkg::ADDR_BITS-1:2] == cta_pkg::REG_MAX_MISSED);
	assign prdata  = reg_sel ? cta_pkg::DATA_BITS'(max_missed_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_missed_q <= cta_pkg::MAX_MISSED_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_missed_q <= pwdata[cta_pkg::MISS_BITS-1:0];
		end
	end

	cta_ctrl #(
		.MAX_TRACKS(MAX_TRACKS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.op         (item.op),
		.status     (status),
		.cmd        (cmd),
		.issue_slot (issue_slot),
		.busy       (busy)
	);

	cta_dp #(
		.MAX_TRACKS(MAX_TRACKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.issue_slot   (issue_slot),
		.item         (item),
		.max_missed   (max_missed_q),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);

	`CTA_ASSERT_NOW(a_result_after_busy, clk, arst_n, result_valid, $past(busy), "result beat without a preceding busy cycle")
	`CTA_ASSERT_NEXT(a_start_sets_busy, clk, arst_n, start && !busy, busy, "accepted item did not raise busy")
	`CTA_ASSERT_NOW(a_new_or_full, clk, arst_n, result_valid, !(result.is_new && result.table_full), "detection both opened a track and reported a full table")
	`CTA_ASSERT_NOW(a_detect_is_last, clk, arst_n, result_valid && result.kind == cta_pkg::KIND_DETECT, result.last && !$past(busy, 2) == 1'b0, "detection result not marked last")

endmodule

`default_nettype wire

>>> test/track_check_pkg.sv
// Scoreboard for the circle track association testbench: predicts every report and checks it.
package track_check_pkg;
	timeunit 1ns;
	timeprecision 1ps;

	import cta_pkg::*;

	localparam logic OP_DETECT = ~OP_END_FRAME;

	class track_board;
		logic                  live [MAX_TRACKS];
		logic [ID_BITS-1:0]    ident [MAX_TRACKS];
		logic [COORD_BITS-1:0] cx [MAX_TRACKS];
		logic [COORD_BITS-1:0] cy [MAX_TRACKS];
		logic [RAD_BITS-1:0]   rad [MAX_TRACKS];
		logic [MISS_BITS-1:0]  missed [MAX_TRACKS];
		logic                  hit [MAX_TRACKS];
		logic [ID_BITS-1:0]    next_ident;
		logic [MISS_BITS-1:0]  miss_limit;
		result_t               awaited_reports [$];
		int errors;
		int beats;
		int frames;
		int matched;
		int opened;
		int refused;
		int checked;

		function new();
			for (int s = 0; s < MAX_TRACKS; s++) begin
				live[s] = 1'b0;
				hit[s] = 1'b0;
			end
			next_ident = '0;
			miss_limit = MAX_MISSED_RESET;
			errors = 0;
			beats = 0;
			frames = 0;
			matched = 0;
			opened = 0;
			refused = 0;
			checked = 0;
		endfunction

		function void set_miss_limit(logic [MISS_BITS-1:0] value);
			miss_limit = value;
		endfunction

		// A larger age is an older track; the id counter wraps, so age wraps with it.
		function logic [ID_BITS-1:0] age(int s);
			return next_ident - ident[s];
		endfunction

		function void note_item(item_t it);
			beats++;
			if (it.op == OP_END_FRAME)
				close_frame();
			else
				place_detection(it);
		endfunction

		function void place_detection(item_t it);
			logic [31:0]        half;
			logic [31:0]        lim;
			logic [31:0]        dx;
			logic [31:0]        dy;
			logic [ID_BITS-1:0] best_age;
			int                 best;
			result_t            r;
			half = 32'(it.radius >> 1);
			lim = half * half;
			best = -1;
			best_age = '0;
			for (int s = 0; s < MAX_TRACKS; s++) begin
				if (!live[s])
					continue;
				dx = cx[s] > it.center_x ? 32'(cx[s] - it.center_x) : 32'(it.center_x - cx[s]);
				dy = cy[s] > it.center_y ? 32'(cy[s] - it.center_y) : 32'(it.center_y - cy[s]);
				if (dx * dx + dy * dy >= lim)
					continue;
				if (best < 0 || age(s) > best_age) begin
					best = s;
					best_age = age(s);
				end
			end
			r = '0;
			r.kind = KIND_DETECT;
			r.track_x = it.center_x;
			r.track_y = it.center_y;
			r.track_radius = it.radius;
			r.last = 1'b1;
			if (best < 0) begin
				for (int s = 0; s < MAX_TRACKS; s++) begin
					if (!live[s]) begin
						best = s;
						break;
					end
				end
				if (best < 0) begin
					r.table_full = 1'b1;
					refused++;
					awaited_reports.push_back(r);
					return;
				end
				live[best] = 1'b1;
				ident[best] = next_ident;
				missed[best] = '0;
				next_ident = next_ident + 1'b1;
				r.is_new = 1'b1;
				opened++;
			end else begin
				matched++;
			end
			cx[best] = it.center_x;
			cy[best] = it.center_y;
			rad[best] = it.radius;
			hit[best] = 1'b1;
			r.track_id = ident[best];
			awaited_reports.push_back(r);
		endfunction

		function void close_frame();
			int      order [MAX_TRACKS];
			int      n;
			int      v;
			int      j;
			result_t r;
			n = 0;
			frames++;
			for (int s = 0; s < MAX_TRACKS; s++) begin
				if (!live[s])
					continue;
				if (hit[s]) begin
					missed[s] = '0;
				end else begin
					if (missed[s] != MISS_MAX)
						missed[s]++;
					if (missed[s] > miss_limit) begin
						live[s] = 1'b0;
						continue;
					end
				end
				order[n] = s;
				n++;
			end
			for (int s = 0; s < MAX_TRACKS; s++)
				hit[s] = 1'b0;
			r = '0;
			r.last = 1'b1;
			if (n == 0) begin
				r.kind = KIND_EMPTY;
				awaited_reports.push_back(r);
				return;
			end
			// Stable insertion sort, oldest first; equal ages keep slot order.
			for (int i = 1; i < n; i++) begin
				v = order[i];
				j = i - 1;
				while (j >= 0 && age(order[j]) < age(v)) begin
					order[j + 1] = order[j];
					j--;
				end
				order[j + 1] = v;
			end
			for (int i = 0; i < n; i++) begin
				r.kind = KIND_TRACK;
				r.track_id = ident[order[i]];
				r.track_x = cx[order[i]];
				r.track_y = cy[order[i]];
				r.track_radius = rad[order[i]];
				r.last = (i == n - 1);
				awaited_reports.push_back(r);
			end
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (awaited_reports.size() == 0) begin
				errors++;
				$display("%0t: report with none expected, expected nothing, actual %p", $time, got);
				return;
			end
			want = awaited_reports.pop_front();
			checked++;
			field_check("kind", want.kind, got.kind);
			field_check("track_id", want.track_id, got.track_id);
			field_check("track_x", want.track_x, got.track_x);
			field_check("track_y", want.track_y, got.track_y);
			field_check("track_radius", want.track_radius, got.track_radius);
			field_check("is_new", want.is_new, got.is_new);
			field_check("table_full", want.table_full, got.table_full);
			field_check("last", want.last, got.last);
		endfunction
	endclass

endpackage

>>> test/tb_circle_track_association_top.sv
// Testbench top: drives detections, frame ends and register writes into the tracker.
module tb_circle_track_association_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cta_pkg::*;
	import track_check_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_BEATS = 54;
	localparam int DRAIN_CYCLES = 400;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	item_t                 item;
	logic                  result_valid;
	result_t               result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_BITS-1:0]  paddr;
	logic [DATA_BITS-1:0]  pwdata;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;

	track_board board;
	logic       no_idle;
	int         cycles = 0;

	circle_track_association_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Reports cannot be held off, so every strobed beat is checked at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1)
			board.check_result(result);
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (no_idle || roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic item_t detection(int x, int y, int r);
		item_t it;
		it.op = OP_DETECT;
		it.center_x = COORD_BITS'(x);
		it.center_y = COORD_BITS'(y);
		it.radius = RAD_BITS'(r);
		return it;
	endfunction

	function automatic item_t frame_end();
		item_t it;
		it = item_t'($urandom);
		it.op = OP_END_FRAME;
		return it;
	endfunction

	// Mostly detections close to a live track, so matches and re-matches dominate.
	function automatic item_t pick_detection();
		item_t it;
		int    s;
		int    roll;
		roll = $urandom_range(9);
		it = detection($urandom_range(100, 160), $urandom_range(100, 160), $urandom_range(80));
		if (roll <= 5) begin
			for (int tries = 0; tries < MAX_TRACKS; tries++) begin
				s = $urandom_range(MAX_TRACKS - 1);
				if (board.live[s]) begin
					it.center_x = board.cx[s] + COORD_BITS'($urandom_range(16)) - COORD_BITS'(8);
					it.center_y = board.cy[s] + COORD_BITS'($urandom_range(16)) - COORD_BITS'(8);
					it.radius = RAD_BITS'($urandom_range(16, 160));
					break;
				end
			end
		end else if (roll == 8) begin
			it.center_x = COORD_BITS'($urandom);
			it.center_y = COORD_BITS'($urandom);
			it.radius = RAD_BITS'($urandom);
		end else if (roll == 9) begin
			it.center_x = $urandom_range(1) ? '1 : '0;
			it.center_y = $urandom_range(1) ? '1 : '0;
			it.radius = $urandom_range(1) ? RAD_BITS'($urandom_range(3)) : '1 - RAD_BITS'($urandom_range(1));
		end
		return it;
	endfunction

	// Start stays high across back-to-back beats; it only drops during a gap.
	task automatic send_beat(item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		board.note_item(it);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (board.awaited_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_miss_limit(logic [MISS_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_MAX_MISSED, 2'b00};
		pwdata <= DATA_BITS'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_miss_limit(value);
	endtask

	initial begin
		logic [MISS_BITS-1:0] limits [6];
		int                   sent;
		int                   burst;
		board = new();
		no_idle = 1'b0;
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, zero half radius, extremes, exact boundary, full table.
		send_beat(frame_end());
		send_beat(detection(0, 0, 0));
		send_beat(detection(4095, 4095, 2047));
		send_beat(detection(4095, 4095, 2047));
		send_beat(detection(0, 0, 3));
		send_beat(detection(1, 0, 2));
		for (int k = 0; k < MAX_TRACKS - 3; k++)
			send_beat(detection(300 * k + 7, 4000 - 250 * k, 0));
		send_beat(detection(2048, 2048, 0));
		send_beat(frame_end());
		settle();
		write_miss_limit('0);
		send_beat(frame_end());

		limits[0] = MISS_MAX;
		limits[1] = '0;
		limits[2] = MISS_BITS'(1);
		limits[3] = MISS_BITS'($urandom_range(2, 254));
		limits[4] = MISS_BITS'(3);
		limits[5] = MAX_MISSED_RESET;
		for (int p = 0; p < 6; p++) begin
			settle();
			write_miss_limit(limits[p]);
			no_idle = ($urandom_range(2) == 0);
			sent = 0;
			while (sent < PHASE_BEATS) begin
				burst = $urandom_range(6);
				repeat (burst) begin
					send_beat(pick_detection());
					sent++;
				end
				send_beat(frame_end());
				sent++;
			end
		end

		start <= 1'b0;
		while (board.awaited_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d beats over %0d frames with six aging limits including 0 and 255.",
			board.beats, board.frames);
		$display("Checked %0d reports: %0d matches, %0d new tracks, %0d refused on a full table.",
			board.checked, board.matched, board.opened, board.refused);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
